// ----- rtl/core/rrsq_pkg.sv -----
// ----------------------------------------------------------------------------
// rrsq_pkg
// Shared constants, codes and types of the round-robin slice queue.
// ----------------------------------------------------------------------------
package rrsq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_BITS   = 16;

   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int BURST_W     = 16;
   localparam int SLICE_W     = 16;
   localparam int REMAIN_W    = 16;
   localparam int PENDING_W   = 5;
   localparam int STATUS_W    = 3;

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXECUTE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REQUEUED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_COMPLETED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   typedef logic [TIME_BITS-1:0] time_type;

   typedef struct packed {
      logic     shift;
      logic     load;
      time_type load_data;
   } cell_ctl_type;

endpackage

// ----- rtl/core/round_robin_slice_queue_top.sv -----
// ----------------------------------------------------------------------------
// round_robin_slice_queue_top
// Round-robin time-slice queue held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_stall) carries one word per command:
// req_op selects insert or execute, req_burst_time is the time to insert.
// Response channel (rsp_valid/rsp_stall) returns exactly one word per
// command: status, remaining time of a requeued head, and pending count.
// The time slice is written through csr_valid/csr_ready/csr_data; the user must
// write it only while idle, as the block does not enforce this; csr_ready is always high.
// The head entry sits in the first cell; a non-empty execute shifts the row by
// one and, for a requeued head, reloads the reduced time at the tail cell in the same cycle.
// rsp_valid rises in the cycle after accept; one command is taken every cycle
// unless req_stall is raised.
// While rsp_stall holds a pending response, req_stall is raised and the
// response word is held.
// Synchronous reset empties the queue and sets the time slice to 1; cell
// contents are not cleared.
// ----------------------------------------------------------------------------
module round_robin_slice_queue_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic [rrsq_pkg::BURST_W-1:0]    req_burst_time,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rrsq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [rrsq_pkg::REMAIN_W-1:0]   rsp_remaining,
   output logic [rrsq_pkg::PENDING_W-1:0]  rsp_pending,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rrsq_pkg::SLICE_W-1:0]    csr_data
);

   localparam int QD = rrsq_pkg::QUEUE_DEPTH;
   localparam int CW = rrsq_pkg::COUNT_W;

   logic [rrsq_pkg::SLICE_W-1:0]   slice_ff;
   logic [rrsq_pkg::SLICE_W-1:0]   slice_in;
   logic [CW-1:0]                  count_ff;
   logic [CW-1:0]                  count_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic [rrsq_pkg::STATUS_W-1:0]  status_ff;
   logic [rrsq_pkg::STATUS_W-1:0]  status_in;
   logic [rrsq_pkg::REMAIN_W-1:0]  remain_ff;
   logic [rrsq_pkg::REMAIN_W-1:0]  remain_in;
   logic [rrsq_pkg::PENDING_W-1:0] pending_ff;
   logic [rrsq_pkg::PENDING_W-1:0] pending_in;

   logic                           accept;
   logic                           shift;
   logic                           load;
   logic [CW-1:0]                  load_pos;
   rrsq_pkg::time_type             load_data;
   rrsq_pkg::time_type             head;
   rrsq_pkg::time_type             slice;
   rrsq_pkg::time_type             left;
   rrsq_pkg::time_type             cell_data [QD];

   assign accept    = req_valid & ~req_stall;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign csr_ready = 1'b1;

   assign slice = rrsq_pkg::TIME_BITS'(slice_ff);
   assign head  = cell_data[0];
   assign left  = head - slice;

   always_comb begin
      slice_in   = slice_ff;
      count_in   = count_ff;
      shift      = 1'b0;
      load       = 1'b0;
      load_pos   = count_ff;
      load_data  = rrsq_pkg::TIME_BITS'(req_burst_time);
      status_in  = status_ff;
      remain_in  = remain_ff;
      pending_in = pending_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      if (csr_valid) begin
         slice_in = csr_data;
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
         remain_in    = '0;
         case (req_op)
            rrsq_pkg::OP_INSERT: begin
               if (count_ff == CW'(QD)) begin
                  status_in = rrsq_pkg::ST_FULL;
               end else begin
                  load      = 1'b1;
                  count_in  = count_ff + 1'b1;
                  status_in = rrsq_pkg::ST_INSERTED;
               end
            end
            default: begin
               if (count_ff == '0) begin
                  status_in = rrsq_pkg::ST_EMPTY;
               end else if (head <= slice) begin
                  shift     = 1'b1;
                  count_in  = count_ff - 1'b1;
                  status_in = rrsq_pkg::ST_COMPLETED;
               end else begin
                  shift     = 1'b1;
                  load      = 1'b1;
                  load_pos  = count_ff - 1'b1;
                  load_data = left;
                  status_in = rrsq_pkg::ST_REQUEUED;
                  remain_in = rrsq_pkg::REMAIN_W'(left);
               end
            end
         endcase
         pending_in = rrsq_pkg::PENDING_W'(count_in);
      end
   end

   for (genvar i = 0; i < QD; i++) begin : g_cell
      rrsq_pkg::cell_ctl_type ctl;
      rrsq_pkg::time_type     next_data;

      assign ctl.shift     = shift;
      assign ctl.load      = load & (load_pos == CW'(i));
      assign ctl.load_data = load_data;

      if (i == QD - 1) begin : g_last
         assign next_data = cell_data[i];
      end else begin : g_mid
         assign next_data = cell_data[i+1];
      end

      rrsq_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .next_data (next_data),
         .data      (cell_data[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_ff     <= rrsq_pkg::SLICE_W'(1);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slice_ff     <= slice_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      remain_ff  <= remain_in;
      pending_ff <= pending_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_remaining = remain_ff;
   assign rsp_pending   = pending_ff;

endmodule

// ----- rtl/core/rrsq_cell.sv -----
// ----------------------------------------------------------------------------
// rrsq_cell
// One queue slot: loads a new time word or takes its right neighbor's word.
// ----------------------------------------------------------------------------
module rrsq_cell (
   input  logic                  clock,
   input  rrsq_pkg::cell_ctl_type ctl,
   input  rrsq_pkg::time_type    next_data,
   output rrsq_pkg::time_type    data
);

   rrsq_pkg::time_type data_ff;
   rrsq_pkg::time_type data_in;

   always_comb begin
      if (ctl.load) begin
         data_in = ctl.load_data;
      end else if (ctl.shift) begin
         data_in = next_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
